// ===== rtl/core/rvgt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvgt_pkg: shared types and constants
// Widths, limits and controller/datapath interface structs for the grid walk.
// ----------------------------------------------------------------------------
package rvgt_pkg;

    localparam int MaxCells = 64;
    localparam int CntW     = $clog2(MaxCells + 1);
    localparam logic [47:0] TInf = 48'hFFFF_FFFF_FFFF;
    localparam logic [30:0] CellSizeReset = 31'd65536;

    // Division selector for the shared divider.
    typedef enum logic [1:0] {
        DIV_CELL  = 2'd0,
        DIV_TMAX  = 2'd1,
        DIV_DELTA = 2'd2
    } div_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      div_start;
        div_kind_t div_kind;
        logic [1:0] axis;
        logic      div_store;
        logic      walk_step;
    } rvgt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic stop_dist;
    } rvgt_sts_t;

endpackage

// ===== rtl/core/rvgt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvgt_div: radix-2 restoring divider
// Unsigned 64 by 32 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rvgt_div
    import rvgt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [31:0] remainder
);

    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    // One shift and trial subtract per cycle.
    assign shifted = {rem_reg[31:0], quo_reg[63]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                if (!trial[32]) begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[31:0];

endmodule

// ===== rtl/core/rvgt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvgt_datapath: ray set-up and walk datapath
// Holds ray operands, per-axis cell, step, tMax and tDelta, and the walk.
// ----------------------------------------------------------------------------
module rvgt_datapath
    import rvgt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [30:0]      cell_size,
    input  logic [95:0]      origin,
    input  logic [95:0]      dir,
    input  logic [30:0]      max_distance,
    input  rvgt_cmd_t        cmd,
    output rvgt_sts_t        sts,
    output logic [95:0]      cells
);

    logic [31:0] org_reg [3];
    logic [31:0] dir_reg [3];
    logic [31:0] cell_reg [3];
    logic [31:0] rem_reg [3];
    logic [1:0]  step_reg [3];
    logic [47:0] tmax_reg [3];
    logic [47:0] tdel_reg [3];
    logic [30:0] maxd_reg;
    logic [31:0] cs_reg;

    logic [63:0] dvd;
    logic [31:0] dvs;
    logic        div_done;
    logic [63:0] quo;
    logic [31:0] rem;

    logic [31:0] o_sel, d_sel, mag, o_mag, num;
    logic        o_neg;
    logic [1:0]  ax;
    logic [48:0] sum;
    logic [47:0] qsat;

    always_comb begin
        o_sel = org_reg[cmd.axis];
        d_sel = dir_reg[cmd.axis];
        o_neg = o_sel[31];
        o_mag = o_neg ? (~o_sel + 32'd1) : o_sel;
        mag   = d_sel[31] ? (~d_sel + 32'd1) : d_sel;
        num   = d_sel[31] ? rem_reg[cmd.axis] : (cs_reg - rem_reg[cmd.axis]);
        case (cmd.div_kind)
            DIV_CELL: begin
                dvd = {32'd0, o_mag};
                dvs = cs_reg;
            end
            DIV_TMAX: begin
                dvd = {16'd0, num, 16'd0};
                dvs = mag;
            end
            default: begin
                dvd = {16'd0, cs_reg, 16'd0};
                dvs = mag;
            end
        endcase
        qsat = (quo[63:48] != 16'd0) ? TInf : quo[47:0];
    end

    rvgt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dvs),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // Axis with the smallest tMax, ties to z then y.
    always_comb begin
        if (tmax_reg[0] < tmax_reg[1])
            ax = (tmax_reg[0] < tmax_reg[2]) ? 2'd0 : 2'd2;
        else
            ax = (tmax_reg[1] < tmax_reg[2]) ? 2'd1 : 2'd2;
        sum = {1'b0, tmax_reg[ax]} + {1'b0, tdel_reg[ax]};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                org_reg[i] <= origin[32*i +: 32];
                dir_reg[i] <= dir[32*i +: 32];
            end
            maxd_reg <= max_distance;
            cs_reg   <= (cell_size == 31'd0) ? 32'd1 : {1'b0, cell_size};
        end
        // Store a finished quotient.
        if (cmd.div_store) begin
            case (cmd.div_kind)
                DIV_CELL: begin
                    if (o_neg && rem != 32'd0) begin
                        cell_reg[cmd.axis] <= ~quo[31:0];
                        rem_reg[cmd.axis]  <= cs_reg - rem;
                    end else begin
                        cell_reg[cmd.axis] <= o_neg ? (~quo[31:0] + 32'd1) : quo[31:0];
                        rem_reg[cmd.axis]  <= rem;
                    end
                    step_reg[cmd.axis] <= (d_sel == 32'd0) ? 2'b00 :
                                          (d_sel[31] ? 2'b11 : 2'b01);
                end
                DIV_TMAX: tmax_reg[cmd.axis] <= qsat;
                default:  tdel_reg[cmd.axis] <= qsat;
            endcase
        end
        // Walk one cell along the chosen axis.
        if (cmd.walk_step) begin
            cell_reg[ax] <= cell_reg[ax] + {{30{step_reg[ax][1]}}, step_reg[ax]};
            tmax_reg[ax] <= sum[48] || sum[47:0] == TInf ? TInf :
                            (sum[47:0] > TInf ? TInf : sum[47:0]);
        end
        // A zero direction leaves both timings at infinity.
        if (cmd.div_store && cmd.div_kind == DIV_CELL && d_sel == 32'd0) begin
            tmax_reg[cmd.axis] <= TInf;
            tdel_reg[cmd.axis] <= TInf;
        end
    end

    assign sts.div_done  = div_done;
    assign sts.stop_dist = tmax_reg[ax] > {17'd0, maxd_reg};
    assign cells = {cell_reg[2], cell_reg[1], cell_reg[0]};

endmodule

// ===== rtl/core/rvgt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvgt_ctrl: traversal sequencer
// Runs the set-up divisions, then emits one cell per accepted output.
// ----------------------------------------------------------------------------
module rvgt_ctrl
    import rvgt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        out_last,
    output logic        out_trunc,
    input  logic        dir_zero_x,
    input  logic        dir_zero_y,
    input  logic        dir_zero_z,
    input  rvgt_sts_t   sts,
    output rvgt_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_WAIT, ST_EMIT
    } state_t;

    state_t      state_reg;
    div_kind_t   kind_reg;
    logic [1:0]  axis_reg;
    logic [CntW-1:0] count_reg;
    logic        zero_sel;
    logic        fin;

    always_comb begin
        case (axis_reg)
            2'd0:    zero_sel = dir_zero_x;
            2'd1:    zero_sel = dir_zero_y;
            default: zero_sel = dir_zero_z;
        endcase
        fin = sts.stop_dist || (count_reg == CntW'(MaxCells - 1));
    end

    always_comb begin
        cmd           = '0;
        cmd.load      = (state_reg == ST_IDLE) && s_tvalid;
        cmd.div_start = (state_reg == ST_START);
        cmd.div_kind  = kind_reg;
        cmd.axis      = axis_reg;
        cmd.div_store = (state_reg == ST_WAIT) && sts.div_done;
        cmd.walk_step = (state_reg == ST_EMIT) && m_tready;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_EMIT);
    assign out_last  = fin;
    assign out_trunc = !sts.stop_dist && (count_reg == CntW'(MaxCells - 1));

    // Sequence: per axis cell division, then tMax and tDelta unless idle axis.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= DIV_CELL;
            axis_reg  <= 2'd0;
            count_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_START;
                        kind_reg  <= DIV_CELL;
                        axis_reg  <= 2'd0;
                        count_reg <= '0;
                    end
                end
                ST_START: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (sts.div_done) begin
                        if (kind_reg == DIV_CELL && !zero_sel) begin
                            state_reg <= ST_START;
                            kind_reg  <= DIV_TMAX;
                        end else if (kind_reg == DIV_TMAX) begin
                            state_reg <= ST_START;
                            kind_reg  <= DIV_DELTA;
                        end else begin
                            kind_reg <= DIV_CELL;
                            if (axis_reg == 2'd2) begin
                                state_reg <= ST_EMIT;
                            end else begin
                                state_reg <= ST_START;
                                axis_reg  <= axis_reg + 2'd1;
                            end
                        end
                    end
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        count_reg <= count_reg + CntW'(1);
                        if (fin) state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/ray_voxel_grid_traversal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_voxel_grid_traversal: uniform grid ray walk
// Set-up: up to 9 divisions on one shared divider (fewer for zero direction
// components) before the first cell.
// Throughput: then one cell per cycle while m_tready is high, up to 64 cells;
// the next request is taken from the cycle after the last cell.
// Reset: aresetn synchronous active low; cell_size returns to 1.0.
// ----------------------------------------------------------------------------
module ray_voxel_grid_traversal
    import rvgt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [30:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, zero pad
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cell_x, cell_y, cell_z
    output logic [95:0]  m_tdata,
    // truncated
    output logic         m_tuser,
    output logic         m_tlast
);

    logic [30:0] cs_reg;
    rvgt_cmd_t   cmd;
    rvgt_sts_t   sts;
    logic [95:0] cells;
    logic        trunc;
    logic [2:0]  u_dp_zero;
    logic [2:0]  zero_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) cs_reg <= CellSizeReset;
        else if (cfg_we) cs_reg <= cfg_wdata;
    end

    rvgt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_last   (m_tlast),
        .out_trunc  (trunc),
        .dir_zero_x (u_dp_zero[0]),
        .dir_zero_y (u_dp_zero[1]),
        .dir_zero_z (u_dp_zero[2]),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Zero direction flags, held with the ray.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            zero_reg[0] <= (s_tdata[127:96]  == 32'd0);
            zero_reg[1] <= (s_tdata[159:128] == 32'd0);
            zero_reg[2] <= (s_tdata[191:160] == 32'd0);
        end
    end
    assign u_dp_zero = zero_reg;

    rvgt_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cell_size    (cs_reg),
        .origin       (s_tdata[95:0]),
        .dir          (s_tdata[191:96]),
        .max_distance (s_tdata[222:192]),
        .cmd          (cmd),
        .sts          (sts),
        .cells        (cells)
    );

    assign m_tdata = cells;
    assign m_tuser = trunc;

endmodule
